/* rtl/assert_macros.svh */
// Assertion shorthands used by the RTL sequencer (sts_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* rtl/sts_pkg.sv */
package sts_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS + 1;
  localparam int DVD_W      = ACC_W + 1;
  localparam int DVS_W      = COORD_BITS + 1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_NEXT = 1'b1;

  typedef struct packed {
    logic                         command;
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic [31:0]                  fill_color;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] row;
    logic signed [COORD_BITS-1:0] x_from;
    logic signed [COORD_BITS-1:0] x_to;
    logic [31:0]                  span_color;
    logic                         last;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_SPLIT,
    OP_BOT_L,
    OP_BOT_R,
    OP_TOP_L,
    OP_TOP_R
  } div_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_BOTTOM,
    ST_TOP
  } ctrl_state_t;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_t op;
    logic    init_bottom;
    logic    init_top;
    logic    emit;
    logic    top;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flat_bottom;
    logic flat_top;
    logic split;
    logic row_eq;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

/* rtl/scanline_triangle_span_walker_top.sv */
// Scanline triangle span walker.
// Input channel in_valid/in_ready/in_word: a word with command load latches
// three vertices and a fill colour; a word with command next asks for one span.
// Output channel out_valid/out_ready/out_word: one span word per next command
// (row, x_from, x_to, span_color, last). A next word while no triangle is being
// walked is taken and dropped. A load replaces any walk in progress.
// A next word yields its span in the following cycle; spans sustain one per
// cycle while the receiver takes them. A load keeps in_ready low for set-up: a
// classify state, then per division a start state and a wait state on the
// shared restoring divider (30 quotient steps, then done); two divisions for
// flat cases, five for a split triangle (split x and four slopes).
// Reset (synchronous, rst high) empties the output register and returns the walk
// to idle. While the receiver stalls with a word waiting, in_ready drops and
// the waiting word holds.
module scanline_triangle_span_walker_top import sts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: load, divisions, walk.
  sts_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_word.command),
    .status     (status),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  // Sort, divider, edge accumulators and output register.
  sts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

/* rtl/sts_div.sv */
module sts_div import sts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic signed [DVS_W-1:0] divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dmag;
  logic [DVD_W-1:0] dq;
  logic             neg;
  logic             dzero;

  logic [DVS_W:0]   rem_sh;
  logic             take;
  logic [DVS_W-1:0] rem_next;
  logic [DVD_W-1:0] dq_next;

  // One restoring step per cycle, quotient bits shift in behind the dividend.
  always_comb begin
    rem_sh   = {rem, dq[DVD_W-1]};
    take     = rem_sh >= {1'b0, dmag};
    rem_next = take ? DVS_W'(rem_sh - {1'b0, dmag}) : DVS_W'(rem_sh);
    dq_next  = {dq[DVD_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      dq    <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
      dmag  <= divisor[DVS_W-1] ? DVS_W'(-divisor) : DVS_W'(divisor);
      neg   <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
      dzero <= divisor == '0;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= dq_next;
      if (cnt == CNT_LAST) begin
        if (dzero) quotient <= '0;
        else quotient <= neg ? DVD_W'(-$signed(dq_next)) : $signed(dq_next);
      end
    end
  end

endmodule

/* rtl/sts_datapath.sv */
module sts_datapath import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_word_t   in_word,
  input  ctrl_cmd_t  cmd,
  input  logic       out_ready,
  output dp_status_t status,
  output logic       out_valid,
  output out_word_t  out_word
);

  typedef logic signed [COORD_BITS-1:0] crd_t;
  typedef logic signed [COORD_BITS:0]   dif_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  crd_t sx0, sy0, sx1, sy1, sx2, sy2;
  crd_t split_x;
  crd_t row;
  logic [31:0] color;
  logic flat_bottom, flat_top;
  acc_t acc0, acc1;
  acc_t bs0, bs1, ts0, ts1;

  crd_t vx0, vy0, vx1, vy1, vx2, vy2, tx, ty;

  // Three compare-swaps, swap only when strictly greater.
  always_comb begin
    tx = '0; ty = '0;
    vx0 = in_word.vertex_a_x; vy0 = in_word.vertex_a_y;
    vx1 = in_word.vertex_b_x; vy1 = in_word.vertex_b_y;
    vx2 = in_word.vertex_c_x; vy2 = in_word.vertex_c_y;
    if (vy0 > vy1) begin
      tx = vx0; ty = vy0; vx0 = vx1; vy0 = vy1; vx1 = tx; vy1 = ty;
    end
    if (vy1 > vy2) begin
      tx = vx1; ty = vy1; vx1 = vx2; vy1 = vy2; vx2 = tx; vy2 = ty;
    end
    if (vy0 > vy1) begin
      tx = vx0; ty = vy0; vx0 = vx1; vy0 = vy1; vx1 = tx; vy1 = ty;
    end
  end

  // Divider operands per operation.
  logic signed [DVD_W-1:0] dvd, p_a, p_b, p_c, p_d;
  logic signed [DVS_W-1:0] dvs;
  dif_t dx;
  logic signed [DVD_W-1:0] quo;
  logic div_done;

  always_comb begin
    p_a = DVD_W'(sx0);
    p_b = DVD_W'(dif_t'(sy2 - sy0));
    p_c = DVD_W'(dif_t'(sx2 - sx0));
    p_d = DVD_W'(dif_t'(sy1 - sy0));
    dx  = '0;
    dvs = dif_t'(sy1 - sy0);
    dvd = '0;
    unique case (cmd.op)
      OP_SPLIT: begin
        dvs = dif_t'(sy2 - sy0);
        dvd = DVD_W'(p_a * p_b + p_c * p_d);
      end
      OP_BOT_L: dx = dif_t'(sx1 - sx0);
      OP_BOT_R: dx = flat_bottom ? dif_t'(sx2 - sx0) : dif_t'(split_x - sx0);
      OP_TOP_L: dx = flat_top ? dif_t'(sx2 - sx0) : dif_t'(sx2 - sx1);
      OP_TOP_R: dx = flat_top ? dif_t'(sx2 - sx1) : dif_t'(sx2 - split_x);
      default:  dx = '0;
    endcase
    if (cmd.op != OP_SPLIT) begin
      dvd = DVD_W'(dx) <<< FRAC_BITS;
      if (cmd.op == OP_TOP_L || cmd.op == OP_TOP_R) dvs = dif_t'(sy2 - sy1);
    end
  end

  sts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Span ends: truncate toward zero.
  dif_t int0, int1;
  always_comb begin
    int0 = acc0[ACC_W-1:FRAC_BITS];
    int1 = acc1[ACC_W-1:FRAC_BITS];
    if (acc0[ACC_W-1] && acc0[FRAC_BITS-1:0] != '0) int0 = dif_t'(int0 + 1'b1);
    if (acc1[ACC_W-1] && acc1[FRAC_BITS-1:0] != '0) int1 = dif_t'(int1 + 1'b1);
  end

  logic row_eq;
  assign row_eq = row == sy1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx0 <= vx0; sy0 <= vy0; sx1 <= vx1; sy1 <= vy1; sx2 <= vx2; sy2 <= vy2;
      color       <= in_word.fill_color;
      flat_bottom <= vy1 == vy2;
      flat_top    <= (vy1 != vy2) && (vy0 == vy1);
    end
    if (div_done) begin
      unique case (cmd.op)
        OP_SPLIT: split_x <= quo[COORD_BITS-1:0];
        OP_BOT_L: bs0 <= quo[ACC_W-1:0];
        OP_BOT_R: bs1 <= quo[ACC_W-1:0];
        OP_TOP_L: ts0 <= quo[ACC_W-1:0];
        OP_TOP_R: ts1 <= quo[ACC_W-1:0];
        default:  ;
      endcase
    end
    if (cmd.init_bottom) begin
      acc0 <= acc_t'(sx0) <<< FRAC_BITS;
      acc1 <= acc_t'(sx0) <<< FRAC_BITS;
      row  <= sy0;
    end else if (cmd.init_top || (cmd.emit && !cmd.top && row_eq)) begin
      acc0 <= acc_t'(sx2) <<< FRAC_BITS;
      acc1 <= acc_t'(sx2) <<< FRAC_BITS;
      row  <= sy2;
    end else if (cmd.emit) begin
      if (cmd.top) begin
        acc0 <= acc0 - ts0;
        acc1 <= acc1 - ts1;
        row  <= row - 1'b1;
      end else begin
        acc0 <= acc0 + bs0;
        acc1 <= acc1 + bs1;
        row  <= row + 1'b1;
      end
    end
    if (cmd.emit) begin
      out_word.row        <= row;
      out_word.x_from     <= int0[COORD_BITS-1:0];
      out_word.x_to       <= int1[COORD_BITS-1:0];
      out_word.span_color <= color;
      out_word.last       <= row_eq && (cmd.top || flat_bottom);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    status.flat_bottom = flat_bottom;
    status.flat_top    = flat_top;
    status.split       = !flat_bottom && !flat_top;
    status.row_eq      = row_eq;
    status.div_done    = div_done;
    status.out_busy    = out_valid && !out_ready;
  end

endmodule

/* rtl/sts_ctrl.sv */
`include "assert_macros.svh"

module sts_ctrl import sts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_command,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;
  div_op_t     op, op_next;
  logic        accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_SPLIT;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    cmd.top    = state == ST_TOP;
    in_ready   = (state == ST_IDLE || state == ST_BOTTOM || state == ST_TOP)
                 && !status.out_busy;
    accept     = in_valid && in_ready;
    unique case (state)
      ST_IDLE, ST_BOTTOM, ST_TOP: begin
        if (accept && in_command == CMD_LOAD) begin
          cmd.load   = 1'b1;
          state_next = ST_SETUP;
        end else if (accept && state != ST_IDLE) begin
          cmd.emit = 1'b1;
          if (status.row_eq) begin
            state_next = (state == ST_BOTTOM && !status.flat_bottom) ? ST_TOP : ST_IDLE;
          end
        end
      end
      ST_SETUP: begin
        op_next    = status.split ? OP_SPLIT : (status.flat_bottom ? OP_BOT_L : OP_TOP_L);
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if ((op == OP_BOT_R && status.flat_bottom) || op == OP_TOP_R) begin
            if (status.flat_top) begin
              cmd.init_top = 1'b1;
              state_next   = ST_TOP;
            end else begin
              cmd.init_bottom = 1'b1;
              state_next      = ST_BOTTOM;
            end
          end else begin
            state_next = ST_DIV_GO;
            unique case (op)
              OP_SPLIT: op_next = OP_BOT_L;
              OP_BOT_L: op_next = OP_BOT_R;
              OP_BOT_R: op_next = OP_TOP_L;
              default:  op_next = OP_TOP_R;
            endcase
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_CLK(a_start_waits, clk, rst, cmd.div_start |=> state == ST_DIV_WAIT, "divider start not followed by wait")
  `ASSERT_CLK(a_op_held, clk, rst, (state == ST_DIV_WAIT && !status.div_done) |=> $stable(op), "operation changed mid-division")
  `ASSERT_NEVER(a_emit_walk, clk, rst, cmd.emit && !(state == ST_BOTTOM || state == ST_TOP), "span emitted outside a walk")
  `ASSERT_NEVER(a_emit_full, clk, rst, cmd.emit && status.out_busy, "span emitted over an untaken word")

endmodule
